### sv/smfd_pkg.sv
// ----------------------------------------------------------------------------
// smfd_pkg
// shared types, constants and arithmetic helpers of the stereo delay block
// ----------------------------------------------------------------------------
package smfd_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 14;
    localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS;
    localparam int SCALED_BITS   = PROD_BITS - GAIN_FRAC;
    localparam int ACC_BITS      = SCALED_BITS + 2;

    localparam int RL_BITS       = 18;
    localparam int DLY_BITS      = 17;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // lanes of the remainder unit
    localparam int RED_LANES = 3;
    localparam int RED_WI    = 0;
    localparam int RED_T1    = 1;
    localparam int RED_T2    = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [GAIN_BITS-1:0]   gain_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [SCALED_BITS-1:0] scaled_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    typedef struct packed {
        sample_t left_sample;
        sample_t right_sample;
    } in_word_t;

    typedef struct packed {
        sample_t left_result;
        sample_t right_result;
    } out_word_t;

    // per-item sequencer steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_RED,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_E1,
        S_MULB,
        S_E2,
        S_MUL3,
        S_SUM
    } state_t;

    // controls from the sequencer to each channel lane
    typedef struct packed {
        logic load_x;
        logic rd_ok0;
        logic rd_ok1;
        logic cap_rb;
        logic cap_t;
        logic mul_b;
        logic cap_e2;
        logic wr_en;
        logic fwd_r;
        logic fwd_b;
        logic fwd_t1;
        logic fwd_t2;
        logic tap1_en;
        logic tap2_en;
    } lane_ctrl_t;

    // q2.14 product scaled back, rounded toward minus infinity
    function automatic scaled_t scale(prod_t p);
        return p[PROD_BITS-1:GAIN_FRAC];
    endfunction

    function automatic sample_t sat_sample(acc_t v);
        logic [ACC_BITS-SAMPLE_BITS:0] hi_bits;
        sample_t r;
        hi_bits = v[ACC_BITS-1:SAMPLE_BITS-1];
        priority if (hi_bits == '0 || hi_bits == '1)
            r = v[SAMPLE_BITS-1:0];
        else if (v[ACC_BITS-1])
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return r;
    endfunction

endpackage

### sv/smfd_reduce.sv
// ----------------------------------------------------------------------------
// smfd_reduce
// bit-serial remainder unit, three dividends against one shared divisor
// ----------------------------------------------------------------------------
module smfd_reduce #(
    parameter int NUM_BITS = 17,
    parameter int DIV_BITS = 18,
    parameter int REM_BITS = 17
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [DIV_BITS-1:0]                           divisor,
    input  logic [smfd_pkg::RED_LANES-1:0][NUM_BITS-1:0]  dividend,
    output logic [smfd_pkg::RED_LANES-1:0][REM_BITS-1:0]  remainder,
    output logic                                          done
);

    localparam int CW = $clog2(NUM_BITS + 1);

    logic                                          busy_reg;
    logic                                          done_reg;
    logic [CW-1:0]                                 cnt_reg;
    logic [DIV_BITS-1:0]                           div_reg;
    logic [smfd_pkg::RED_LANES-1:0][NUM_BITS-1:0]  num_reg;
    logic [smfd_pkg::RED_LANES-1:0][DIV_BITS-1:0]  rem_reg;
    logic [smfd_pkg::RED_LANES-1:0][DIV_BITS-1:0]  rem_next;

    // one quotient bit per cycle in each lane
    always_comb
    begin
        for (int i = 0; i < smfd_pkg::RED_LANES; i++)
        begin
            logic [DIV_BITS:0] trial;
            trial = {rem_reg[i], num_reg[i][NUM_BITS-1]};
            if (trial >= {1'b0, div_reg})
                rem_next[i] = DIV_BITS'(trial - {1'b0, div_reg});
            else
                rem_next[i] = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NUM_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            for (int i = 0; i < smfd_pkg::RED_LANES; i++)
                num_reg[i] <= {num_reg[i][NUM_BITS-2:0], 1'b0};
        end
    end

    always_comb
    begin
        for (int i = 0; i < smfd_pkg::RED_LANES; i++)
            remainder[i] = rem_reg[i][REM_BITS-1:0];
    end

    assign done = done_reg;

endmodule

### sv/smfd_lane.sv
// ----------------------------------------------------------------------------
// smfd_lane
// one channel: ring memory, feedback build of the written entry, tap sum
// ----------------------------------------------------------------------------
module smfd_lane #(
    parameter int RING_DEPTH = 131072
) (
    input  logic                            clk,
    input  smfd_pkg::lane_ctrl_t            ctrl,
    input  smfd_pkg::sample_t               in_sample,
    input  smfd_pkg::gain_t                 feedback_gain,
    input  smfd_pkg::gain_t                 bounce_gain,
    input  smfd_pkg::gain_t                 reverse_gain,
    input  logic [$clog2(RING_DEPTH)-1:0]   rd_addr0,
    input  logic [$clog2(RING_DEPTH)-1:0]   rd_addr1,
    input  logic [$clog2(RING_DEPTH)-1:0]   wr_addr,
    output smfd_pkg::sample_t               result
);

    smfd_pkg::sample_t ring_mem [RING_DEPTH];

    smfd_pkg::sample_t q0_reg;
    smfd_pkg::sample_t q1_reg;
    logic              ok0_reg;
    logic              ok1_reg;
    smfd_pkg::sample_t x_reg;
    smfd_pkg::sample_t vr_reg;
    smfd_pkg::sample_t vb_reg;
    smfd_pkg::sample_t vt1_reg;
    smfd_pkg::sample_t vt2_reg;
    smfd_pkg::sample_t e1_reg;
    smfd_pkg::sample_t e2_reg;
    smfd_pkg::prod_t   p_reg;
    smfd_pkg::prod_t   pa_reg;
    smfd_pkg::prod_t   pb_reg;
    smfd_pkg::prod_t   pc_reg;

    smfd_pkg::sample_t old0;
    smfd_pkg::sample_t old1;
    smfd_pkg::sample_t vr_first;
    smfd_pkg::sample_t vb_eff;
    smfd_pkg::sample_t vr_last;
    smfd_pkg::sample_t vt1_last;
    smfd_pkg::sample_t vt2_last;
    smfd_pkg::sample_t e1_next;
    smfd_pkg::sample_t e2_next;

    // entries at or past the fill mark read as zero
    assign old0 = ok0_reg ? q0_reg : '0;
    assign old1 = ok1_reg ? q1_reg : '0;

    // reads at the write index see the entry as built so far
    assign vr_first = ctrl.fwd_r ? x_reg : old0;
    assign vb_eff   = ctrl.fwd_b ? e1_reg : vb_reg;
    assign vr_last  = ctrl.fwd_r ? e2_reg : vr_reg;
    assign vt1_last = !ctrl.tap1_en ? '0 : (ctrl.fwd_t1 ? e2_reg : vt1_reg);
    assign vt2_last = !ctrl.tap2_en ? '0 : (ctrl.fwd_t2 ? e2_reg : vt2_reg);

    assign e1_next = smfd_pkg::sat_sample(smfd_pkg::acc_t'(x_reg)
                     + smfd_pkg::acc_t'(smfd_pkg::scale(p_reg)));
    assign e2_next = smfd_pkg::sat_sample(smfd_pkg::acc_t'(e1_reg)
                     + smfd_pkg::acc_t'(smfd_pkg::scale(p_reg)));

    assign result = smfd_pkg::sat_sample(smfd_pkg::acc_t'(x_reg)
                    + smfd_pkg::acc_t'(smfd_pkg::scale(pa_reg))
                    + smfd_pkg::acc_t'(smfd_pkg::scale(pb_reg))
                    + smfd_pkg::acc_t'(smfd_pkg::scale(pc_reg)));

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            ring_mem[wr_addr] <= e2_reg;
        q0_reg <= ring_mem[rd_addr0];
        q1_reg <= ring_mem[rd_addr1];
    end

    always_ff @(posedge clk)
    begin
        ok0_reg <= ctrl.rd_ok0;
        ok1_reg <= ctrl.rd_ok1;
        if (ctrl.load_x)
            x_reg <= in_sample;
        if (ctrl.cap_rb)
        begin
            vr_reg <= old0;
            vb_reg <= old1;
            p_reg  <= vr_first * bounce_gain;
        end
        if (ctrl.cap_t)
        begin
            vt1_reg <= old0;
            vt2_reg <= old1;
            e1_reg  <= e1_next;
        end
        if (ctrl.mul_b)
            p_reg <= vb_eff * reverse_gain;
        if (ctrl.cap_e2)
            e2_reg <= e2_next;
        if (ctrl.wr_en)
        begin
            pa_reg <= vr_last * feedback_gain;
            pb_reg <= vt1_last * feedback_gain;
            pc_reg <= vt2_last * feedback_gain;
        end
    end

endmodule

### sv/stereo_multitap_feedback_delay.sv
// ----------------------------------------------------------------------------
// stereo_multitap_feedback_delay
// stereo ring delay with bounce and mirror feedback and two extra taps
// ----------------------------------------------------------------------------
// usage
//   in_data/in_valid/in_ready take one stereo word; out_data/out_valid/
//   out_ready give one saturated stereo word per input word, in order
//   an input buffer holds the next word while the current one is worked,
//   and an output register holds a finished word while the receiver stalls
//   the sequencer works one word at a time; the two channel lanes run side
//   by side, each with a ring memory read at two addresses per cycle, so the
//   four reads per channel use steps RD0 and RD1 and the feedback chain of
//   three dependent multiplies takes the rest; a buffered word starts as the
//   finished one leaves the final step
//   the first word after reset or after any register write first runs the
//   bit-serial remainder unit (write index and tap offsets modulo the ring
//   length)
//   reset: registers take their defaults, write index zero; the rings read
//   as zero through a fill mark, so there is no clearing pass; a stalled
//   receiver holds the sequencer in its final step; the buffered input word
//   waits until the output register frees up; unchecked by the block, the
//   user writes registers over the apb port only while no word is in flight
// ----------------------------------------------------------------------------
module stereo_multitap_feedback_delay #(
    parameter int RING_DEPTH = 131072
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  smfd_pkg::in_word_t                   in_data,
    // output stream
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output smfd_pkg::out_word_t                  out_data,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smfd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [smfd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [smfd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int AW = $clog2(RING_DEPTH);          // ring index
    localparam int LW = $clog2(RING_DEPTH + 1);      // ring length, fill mark
    localparam int SW = LW + 1;                      // index sums
    localparam int XW = (LW > smfd_pkg::RL_BITS) ? LW : smfd_pkg::RL_BITS;
    localparam int NW = (AW > smfd_pkg::DLY_BITS) ? AW : smfd_pkg::DLY_BITS;
    localparam int DW = smfd_pkg::APB_DATA_BITS;

    // register map, word index
    localparam logic [2:0] REG_RING_LENGTH  = 3'd0;
    localparam logic [2:0] REG_DELAY        = 3'd1;
    localparam logic [2:0] REG_TAP1         = 3'd2;
    localparam logic [2:0] REG_TAP2         = 3'd3;
    localparam logic [2:0] REG_FB_GAIN      = 3'd4;
    localparam logic [2:0] REG_BOUNCE_GAIN  = 3'd5;
    localparam logic [2:0] REG_REVERSE_GAIN = 3'd6;

    // ---------------- configuration registers ----------------
    logic [smfd_pkg::RL_BITS-1:0]  ring_length_reg;
    logic [smfd_pkg::DLY_BITS-1:0] delay_reg;
    logic [smfd_pkg::DLY_BITS-1:0] tap1_offset_reg;
    logic [smfd_pkg::DLY_BITS-1:0] tap2_offset_reg;
    smfd_pkg::gain_t               feedback_gain_reg;
    smfd_pkg::gain_t               bounce_gain_reg;
    smfd_pkg::gain_t               reverse_gain_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[smfd_pkg::APB_ADDR_BITS-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg   <= smfd_pkg::RL_BITS'(131072);
            delay_reg         <= '0;
            tap1_offset_reg   <= '0;
            tap2_offset_reg   <= '0;
            feedback_gain_reg <= '0;
            bounce_gain_reg   <= '0;
            reverse_gain_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RING_LENGTH:  ring_length_reg   <= pwdata[smfd_pkg::RL_BITS-1:0];
                REG_DELAY:        delay_reg         <= pwdata[smfd_pkg::DLY_BITS-1:0];
                REG_TAP1:         tap1_offset_reg   <= pwdata[smfd_pkg::DLY_BITS-1:0];
                REG_TAP2:         tap2_offset_reg   <= pwdata[smfd_pkg::DLY_BITS-1:0];
                REG_FB_GAIN:      feedback_gain_reg <= pwdata[smfd_pkg::GAIN_BITS-1:0];
                REG_BOUNCE_GAIN:  bounce_gain_reg   <= pwdata[smfd_pkg::GAIN_BITS-1:0];
                REG_REVERSE_GAIN: reverse_gain_reg  <= pwdata[smfd_pkg::GAIN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_RING_LENGTH:  prdata = DW'(ring_length_reg);
            REG_DELAY:        prdata = DW'(delay_reg);
            REG_TAP1:         prdata = DW'(tap1_offset_reg);
            REG_TAP2:         prdata = DW'(tap2_offset_reg);
            REG_FB_GAIN:      prdata = DW'(unsigned'(feedback_gain_reg));
            REG_BOUNCE_GAIN:  prdata = DW'(unsigned'(bounce_gain_reg));
            REG_REVERSE_GAIN: prdata = DW'(unsigned'(reverse_gain_reg));
            default:          prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    smfd_pkg::state_t   state_reg;
    smfd_pkg::state_t   state_next;

    logic               buf_valid_reg;
    smfd_pkg::in_word_t buf_data_reg;
    logic               out_valid_reg;
    smfd_pkg::out_word_t out_data_reg;

    // lane results, merged into one output word
    smfd_pkg::sample_t  left_y;
    smfd_pkg::sample_t  right_y;

    // cached ring geometry; stale after any register write
    logic               stale_reg;
    logic [LW-1:0]      lc_reg;
    logic [AW-1:0]      d_reg;
    logic [AW-1:0]      t1m_reg;
    logic [AW-1:0]      t2m_reg;
    logic [AW-1:0]      wi_reg;
    logic [LW-1:0]      fill_reg;       // entries below this were written

    // per-word read pointers
    logic [AW-1:0]      r_reg;
    logic [AW-1:0]      b_reg;
    logic [AW-1:0]      t1_reg;
    logic [AW-1:0]      t2_reg;

    logic               out_free;
    logic               start_item;

    assign out_free   = !out_valid_reg || out_ready;
    assign start_item = buf_valid_reg
                        && (state_reg == smfd_pkg::S_IDLE
                            || (state_reg == smfd_pkg::S_SUM && out_free));
    assign in_ready   = !buf_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // ---------------- ring length and delay clamps ----------------
    logic [XW-1:0] rl_x;
    logic [XW-1:0] lc_x;
    logic [LW-1:0] lc_next;
    logic [XW-1:0] dl_x;
    logic [XW-1:0] lm1_x;
    logic [AW-1:0] d_next;

    assign rl_x = XW'(ring_length_reg);

    always_comb
    begin
        priority if (rl_x == '0)
            lc_x = XW'(1);
        else if (rl_x > XW'(RING_DEPTH))
            lc_x = XW'(RING_DEPTH);
        else
            lc_x = rl_x;
    end

    assign lc_next = lc_x[LW-1:0];
    assign dl_x    = XW'(delay_reg);
    assign lm1_x   = XW'(lc_reg) - XW'(1);
    assign d_next  = (dl_x > lm1_x) ? lm1_x[AW-1:0] : dl_x[AW-1:0];

    // ---------------- remainder unit ----------------
    logic [smfd_pkg::RED_LANES-1:0][NW-1:0] red_num;
    logic [smfd_pkg::RED_LANES-1:0][AW-1:0] red_rem;
    logic                                   red_done;

    always_comb
    begin
        red_num = '0;
        red_num[smfd_pkg::RED_WI] = NW'(wi_reg);
        red_num[smfd_pkg::RED_T1] = NW'(tap1_offset_reg);
        red_num[smfd_pkg::RED_T2] = NW'(tap2_offset_reg);
    end

    smfd_reduce #(
        .NUM_BITS (NW),
        .DIV_BITS (LW),
        .REM_BITS (AW)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == smfd_pkg::S_CLAMP),
        .divisor   (lc_next),
        .dividend  (red_num),
        .remainder (red_rem),
        .done      (red_done)
    );

    // ---------------- pointer arithmetic ----------------
    logic [SW-1:0] w_s;
    logic [SW-1:0] d_s;
    logic [SW-1:0] l_s;
    logic [SW-1:0] ws_sum;
    logic [SW-1:0] r_s;
    logic [SW-1:0] b_s;
    logic [SW-1:0] t1_s;
    logic [SW-1:0] t2_s;
    logic [SW-1:0] w_inc;
    logic [AW-1:0] wi_next;

    assign w_s    = SW'(wi_reg);
    assign d_s    = SW'(d_reg);
    assign l_s    = SW'(lc_reg);
    assign ws_sum = w_s + d_s;

    // delay read: w - d, wrapped up into the ring
    assign r_s = (w_s >= d_s) ? (w_s - d_s) : (w_s + l_s - d_s);

    // mirror read: -(w + d) mod L, with w + d below 2L
    always_comb
    begin
        priority if (ws_sum == '0)
            b_s = '0;
        else if (ws_sum <= l_s)
            b_s = l_s - ws_sum;
        else
            b_s = {l_s[SW-2:0], 1'b0} - ws_sum;
    end

    // taps: delay point plus the pre-reduced offset, one wrap at most
    always_comb
    begin
        logic [SW-1:0] s1;
        logic [SW-1:0] s2;
        s1 = SW'(r_reg) + SW'(t1m_reg);
        s2 = SW'(r_reg) + SW'(t2m_reg);
        t1_s = (s1 >= l_s) ? (s1 - l_s) : s1;
        t2_s = (s2 >= l_s) ? (s2 - l_s) : s2;
    end

    assign w_inc   = w_s + SW'(1);
    assign wi_next = (w_inc == l_s) ? '0 : w_inc[AW-1:0];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smfd_pkg::S_IDLE:
            begin
                if (start_item)
                    state_next = stale_reg ? smfd_pkg::S_CLAMP : smfd_pkg::S_ADDR;
            end
            smfd_pkg::S_CLAMP: state_next = smfd_pkg::S_RED;
            smfd_pkg::S_RED:
            begin
                if (red_done)
                    state_next = smfd_pkg::S_ADDR;
            end
            smfd_pkg::S_ADDR:  state_next = smfd_pkg::S_RD0;
            smfd_pkg::S_RD0:   state_next = smfd_pkg::S_RD1;
            smfd_pkg::S_RD1:   state_next = smfd_pkg::S_E1;
            smfd_pkg::S_E1:    state_next = smfd_pkg::S_MULB;
            smfd_pkg::S_MULB:  state_next = smfd_pkg::S_E2;
            smfd_pkg::S_E2:    state_next = smfd_pkg::S_MUL3;
            smfd_pkg::S_MUL3:  state_next = smfd_pkg::S_SUM;
            smfd_pkg::S_SUM:
            begin
                // back to back: the buffered word starts as this one leaves
                if (out_free)
                begin
                    if (start_item)
                        state_next = stale_reg ? smfd_pkg::S_CLAMP : smfd_pkg::S_ADDR;
                    else
                        state_next = smfd_pkg::S_IDLE;
                end
            end
            default:           state_next = smfd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= smfd_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            stale_reg     <= 1'b1;
            wi_reg        <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                buf_valid_reg <= 1'b1;
            else if (start_item)
                buf_valid_reg <= 1'b0;

            // merge stage: both lanes land in one output word
            if (state_reg == smfd_pkg::S_SUM && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
                stale_reg <= 1'b1;
            else if (state_reg == smfd_pkg::S_RED && red_done)
                stale_reg <= 1'b0;

            if (state_reg == smfd_pkg::S_RED && red_done)
                wi_reg <= red_rem[smfd_pkg::RED_WI];
            else if (state_reg == smfd_pkg::S_SUM && out_free)
                wi_reg <= wi_next;

            // writes walk upward from zero, so the written set stays contiguous
            if (state_reg == smfd_pkg::S_MUL3 && LW'(wi_reg) == fill_reg)
                fill_reg <= fill_reg + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            buf_data_reg <= in_data;
        if (state_reg == smfd_pkg::S_CLAMP)
            lc_reg <= lc_next;
        if (state_reg == smfd_pkg::S_RED)
            d_reg <= d_next;
        if (state_reg == smfd_pkg::S_RED && red_done)
        begin
            t1m_reg <= red_rem[smfd_pkg::RED_T1];
            t2m_reg <= red_rem[smfd_pkg::RED_T2];
        end
        if (state_reg == smfd_pkg::S_ADDR)
        begin
            r_reg <= r_s[AW-1:0];
            b_reg <= b_s[AW-1:0];
        end
        if (state_reg == smfd_pkg::S_RD0)
        begin
            t1_reg <= t1_s[AW-1:0];
            t2_reg <= t2_s[AW-1:0];
        end
        if (state_reg == smfd_pkg::S_SUM && out_free)
        begin
            out_data_reg.left_result  <= left_y;
            out_data_reg.right_result <= right_y;
        end
    end

    // ---------------- channel lanes ----------------
    smfd_pkg::lane_ctrl_t lane_ctrl;
    logic [AW-1:0]        rd_addr0;
    logic [AW-1:0]        rd_addr1;

    // delay and mirror reads first, the two taps next
    assign rd_addr0 = (state_reg == smfd_pkg::S_RD0) ? r_reg : t1_reg;
    assign rd_addr1 = (state_reg == smfd_pkg::S_RD0) ? b_reg : t2_reg;

    always_comb
    begin
        lane_ctrl.load_x  = start_item;
        lane_ctrl.rd_ok0  = LW'(rd_addr0) < fill_reg;
        lane_ctrl.rd_ok1  = LW'(rd_addr1) < fill_reg;
        lane_ctrl.cap_rb  = state_reg == smfd_pkg::S_RD1;
        lane_ctrl.cap_t   = state_reg == smfd_pkg::S_E1;
        lane_ctrl.mul_b   = state_reg == smfd_pkg::S_MULB;
        lane_ctrl.cap_e2  = state_reg == smfd_pkg::S_E2;
        lane_ctrl.wr_en   = state_reg == smfd_pkg::S_MUL3;
        lane_ctrl.fwd_r   = r_reg == wi_reg;
        lane_ctrl.fwd_b   = b_reg == wi_reg;
        lane_ctrl.fwd_t1  = t1_reg == wi_reg;
        lane_ctrl.fwd_t2  = t2_reg == wi_reg;
        lane_ctrl.tap1_en = tap1_offset_reg != '0;
        lane_ctrl.tap2_en = tap2_offset_reg != '0;
    end

    smfd_lane #(
        .RING_DEPTH (RING_DEPTH)
    ) u_left (
        .clk           (clk),
        .ctrl          (lane_ctrl),
        .in_sample     (buf_data_reg.left_sample),
        .feedback_gain (feedback_gain_reg),
        .bounce_gain   (bounce_gain_reg),
        .reverse_gain  (reverse_gain_reg),
        .rd_addr0      (rd_addr0),
        .rd_addr1      (rd_addr1),
        .wr_addr       (wi_reg),
        .result        (left_y)
    );

    smfd_lane #(
        .RING_DEPTH (RING_DEPTH)
    ) u_right (
        .clk           (clk),
        .ctrl          (lane_ctrl),
        .in_sample     (buf_data_reg.right_sample),
        .feedback_gain (feedback_gain_reg),
        .bounce_gain   (bounce_gain_reg),
        .reverse_gain  (reverse_gain_reg),
        .rd_addr0      (rd_addr0),
        .rd_addr1      (rd_addr1),
        .wr_addr       (wi_reg),
        .result        (right_y)
    );

`ifndef ASSERT_OFF
    // a finished word always lands in the output register
    a_sum_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smfd_pkg::S_SUM && out_free |=> out_valid_reg)
        else $error("finished word not loaded into output register");

    // the write index is inside the ring once pointers are formed
    a_wi_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smfd_pkg::S_ADDR |-> LW'(wi_reg) < lc_reg)
        else $error("write index outside ring length");

    // writes never skip past the fill mark
    a_fill_contig: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smfd_pkg::S_MUL3 |-> LW'(wi_reg) <= fill_reg)
        else $error("ring write beyond fill mark");

    // the remainder unit only finishes while the sequencer waits for it
    a_red_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> state_reg == smfd_pkg::S_RED)
        else $error("remainder done outside reduce step");
`endif

endmodule

### tb/smfd_tb_pkg.sv
// ----------------------------------------------------------------------------
// smfd_tb_pkg
// register map of the stereo delay block as seen by the testbench
// ----------------------------------------------------------------------------
package smfd_tb_pkg;

    // register index, byte address is index times four
    typedef enum logic [2:0] {
        REG_RING_LENGTH,
        REG_DELAY,
        REG_TAP1,
        REG_TAP2,
        REG_FEEDBACK_GAIN,
        REG_BOUNCE_GAIN,
        REG_REVERSE_GAIN,
        REG_UNUSED
    } reg_index_t;

endpackage

### tb/smfd_checker.sv
// ----------------------------------------------------------------------------
// smfd_checker
// watches the stream and register ports, predicts every output word of the
// stereo delay and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module smfd_checker #(
    parameter int RING_DEPTH = 131072
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  smfd_pkg::in_word_t                   in_data,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  smfd_pkg::out_word_t                  out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smfd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [smfd_pkg::APB_DATA_BITS-1:0]   pwdata,
    input  logic                                 pready,
    input  logic                                 drain_done,
    output int                                   pending_words,
    output int                                   mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import smfd_pkg::*;
    import smfd_tb_pkg::*;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // shadow registers
    logic [RL_BITS-1:0]  cfg_ring_length;
    logic [DLY_BITS-1:0] cfg_delay;
    logic [DLY_BITS-1:0] cfg_tap1;
    logic [DLY_BITS-1:0] cfg_tap2;
    gain_t               cfg_fb_gain;
    gain_t               cfg_bounce_gain;
    gain_t               cfg_reverse_gain;

    // shadow rings, channel 0 left, channel 1 right
    sample_t             ring_mem [0:1][0:RING_DEPTH-1];
    logic [16:0]         wr_idx;

    out_word_t           echo_pending [$];
    out_word_t           want;

    initial begin
        pending_words  = 0;
        mismatch_count = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        if (mismatch_count < 200)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic longint gain_mul(input longint s, input gain_t g);
        longint p;
        p = s * longint'(g);
        return p >>> GAIN_FRAC;
    endfunction

    function automatic longint clip(input longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // rebuilds the entry at the write index, then sums the output taps
    function automatic sample_t run_channel(input int ch, input sample_t x,
                                            input int unsigned w, input int unsigned r,
                                            input int unsigned b, input int unsigned len);
        longint      e;
        longint      acc;
        int unsigned t;
        e = longint'(x);
        ring_mem[ch][w] = sample_t'(e);
        e = clip(e + gain_mul(ring_mem[ch][r], cfg_bounce_gain));
        ring_mem[ch][w] = sample_t'(e);
        e = clip(e + gain_mul(ring_mem[ch][b], cfg_reverse_gain));
        ring_mem[ch][w] = sample_t'(e);
        acc = longint'(x) + gain_mul(ring_mem[ch][r], cfg_fb_gain);
        if (cfg_tap1 != 0)
        begin
            t = (r + cfg_tap1) % len;
            acc += gain_mul(ring_mem[ch][t], cfg_fb_gain);
        end
        if (cfg_tap2 != 0)
        begin
            t = (r + cfg_tap2) % len;
            acc += gain_mul(ring_mem[ch][t], cfg_fb_gain);
        end
        return sample_t'(clip(acc));
    endfunction

    function automatic out_word_t predict_echo(input in_word_t din);
        int unsigned len;
        int unsigned dly;
        int unsigned w;
        int unsigned r;
        int unsigned b;
        out_word_t   y;
        len = cfg_ring_length;
        if (len < 1)
            len = 1;
        if (len > RING_DEPTH)
            len = RING_DEPTH;
        dly = cfg_delay;
        if (dly > len - 1)
            dly = len - 1;
        w = wr_idx % len;
        r = (w + len - dly) % len;
        b = (2 * len - w - dly) % len;
        y.left_result  = run_channel(0, din.left_sample, w, r, b, len);
        y.right_result = run_channel(1, din.right_sample, w, r, b, len);
        wr_idx = 17'((w + 1) % len);
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ring_length  = RL_BITS'(131072);
            cfg_delay        = '0;
            cfg_tap1         = '0;
            cfg_tap2         = '0;
            cfg_fb_gain      = '0;
            cfg_bounce_gain  = '0;
            cfg_reverse_gain = '0;
            wr_idx           = '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_mem[0][i] = '0;
                ring_mem[1][i] = '0;
            end
            echo_pending.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[APB_ADDR_BITS-1:2]))
                    REG_RING_LENGTH:   cfg_ring_length  = pwdata[RL_BITS-1:0];
                    REG_DELAY:         cfg_delay        = pwdata[DLY_BITS-1:0];
                    REG_TAP1:          cfg_tap1         = pwdata[DLY_BITS-1:0];
                    REG_TAP2:          cfg_tap2         = pwdata[DLY_BITS-1:0];
                    REG_FEEDBACK_GAIN: cfg_fb_gain      = pwdata[GAIN_BITS-1:0];
                    REG_BOUNCE_GAIN:   cfg_bounce_gain  = pwdata[GAIN_BITS-1:0];
                    REG_REVERSE_GAIN:  cfg_reverse_gain = pwdata[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (echo_pending.size() == 0)
                    report_mismatch("unexpected word, left", out_data.left_result, 0);
                else
                begin
                    want = echo_pending.pop_front();
                    if (out_data.left_result !== want.left_result)
                        report_mismatch("left_result", out_data.left_result,
                                        want.left_result);
                    if (out_data.right_result !== want.right_result)
                        report_mismatch("right_result", out_data.right_result,
                                        want.right_result);
                end
            end
            if (in_valid && in_ready)
                echo_pending.push_back(predict_echo(in_data));
        end
        pending_words = echo_pending.size();
    end

    always @(posedge drain_done)
    begin
        if (echo_pending.size() != 0)
            report_mismatch("words still expected", echo_pending.size(), 0);
    end

endmodule

### tb/stereo_multitap_feedback_delay_tb.sv
// ----------------------------------------------------------------------------
// stereo_multitap_feedback_delay_tb
// drives the stereo delay with directed and random sample words across many
// register settings, with random stalls on both streams; a checker beside
// the block predicts and compares every output word
// ----------------------------------------------------------------------------
module stereo_multitap_feedback_delay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smfd_pkg::*;
    import smfd_tb_pkg::*;

    localparam int RING_DEPTH = 131072;
    localparam int LONG_HOLD  = 150;
    localparam int TAIL_WAIT  = 40;

    localparam logic [31:0] SMP_MAX = 32'h007F_FFFF;
    localparam logic [31:0] SMP_MIN = 32'hFF80_0000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    in_word_t                   in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_word_t                  out_data;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0]   paddr     = '0;
    logic [APB_DATA_BITS-1:0]   pwdata    = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    logic                       drain_done = 1'b0;
    int                         pending_words;
    int                         mismatch_count;

    // flags shared between the sender and the receiver process
    bit                         quiet_mode   = 1'b0;
    bit                         hold_request = 1'b0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    stereo_multitap_feedback_delay #(
        .RING_DEPTH (RING_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    smfd_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) echo_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .drain_done     (drain_done),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    // setup cycle, access cycle, then back to idle on the bus
    task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_setting(input logic [31:0] len, input logic [31:0] dly,
                                 input logic [31:0] t1, input logic [31:0] t2,
                                 input logic [31:0] fg, input logic [31:0] bg,
                                 input logic [31:0] rg);
        reg_write(REG_RING_LENGTH, len);
        reg_write(REG_DELAY, dly);
        reg_write(REG_TAP1, t1);
        reg_write(REG_TAP2, t2);
        reg_write(REG_FEEDBACK_GAIN, fg);
        reg_write(REG_BOUNCE_GAIN, bg);
        reg_write(REG_REVERSE_GAIN, rg);
    endtask

    // hold the word until the block takes it; ready is looked at mid-cycle
    // so the decision never races the edge that moves the word
    task automatic send_word(input logic [31:0] left, input logic [31:0] right);
        bit taken;
        in_data  <= in_word_t'{left_sample: sample_t'(left), right_sample: sample_t'(right)};
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // random idle burst on the input side
    task automatic idle_gap();
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return 32'($signed($urandom_range(0, 255)) - 128);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h0000_4000;
            2:       return 32'hFFFF_C000;
            3:       return 32'h0000_0000;
            default: return 32'($signed($urandom_range(0, 16'h3FFF)) - 16'sh2000);
        endcase
    endfunction

    function automatic logic [31:0] rand_offset(input int unsigned eff);
        case ($urandom_range(0, 5))
            0, 1:    return 32'd0;
            2:       return $urandom();
            default: return $urandom_range(1, 2 * eff);
        endcase
    endfunction

    // new random register set, mostly short rings so the feedback paths
    // actually get exercised within a few dozen words
    task automatic random_setting();
        logic [31:0] len;
        int unsigned eff;
        logic [31:0] dly;
        case ($urandom_range(0, 9))
            0:       len = 32'd0;
            1:       len = 32'd1;
            2:       len = 32'd2;
            7:       len = $urandom_range(65, 4096);
            8:       len = RING_DEPTH;
            9:       len = $urandom();
            default: len = $urandom_range(3, 64);
        endcase
        eff = len[RL_BITS-1:0];
        if (eff < 1)
            eff = 1;
        if (eff > RING_DEPTH)
            eff = RING_DEPTH;
        if ($urandom_range(0, 7) == 0)
            dly = $urandom();
        else
            dly = $urandom_range(0, eff + 2);
        write_setting(len, dly, rand_offset(eff), rand_offset(eff),
                      rand_gain(), rand_gain(), rand_gain());
    endtask

    task automatic random_words(input int count, input bit gapless);
        for (int i = 0; i < count; i++)
        begin
            if (!gapless)
                idle_gap();
            send_word(rand_sample(), rand_sample());
        end
    endtask

    // receiver: random stall bursts, one long hold on request, none when quiet
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_mode && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: long ring, all gains zero, output follows input
        // first word also hits the mirror wrap with write index and delay zero
        send_word(SMP_MAX, SMP_MIN);
        send_word(SMP_MIN, SMP_MAX);
        send_word(32'd0, 32'hFFFF_FFFF);
        send_word(32'd1, 32'd0);
        send_word(SMP_MAX, SMP_MAX);
        wait_for_results();

        // short ring left with the write index past its end, tap2 wraps,
        // extreme gains drive every sum into saturation
        write_setting(32'd4, 32'd1, 32'd1, 32'd6, 32'h0000_7FFF, 32'h0000_7FFF,
                      32'hFFFF_8000);
        // write to an unmapped index must be ignored
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        repeat (3) send_word(SMP_MAX, SMP_MAX);
        repeat (3) send_word(SMP_MIN, SMP_MIN);
        send_word(32'd0, 32'd0);
        send_word(32'd1, 32'hFFFF_FFFF);
        wait_for_results();

        // ring length zero taken as one: delay clamps, every read lands on
        // the entry being built, tap1 wraps to it as well
        write_setting(32'd0, 32'd5, 32'd3, 32'd0, 32'h0000_8000, 32'h0000_8000,
                      32'h0000_7FFF);
        send_word(SMP_MAX, SMP_MIN);
        send_word(SMP_MIN, SMP_MAX);
        send_word(SMP_MAX, SMP_MAX);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_results();

        // ring length above the depth taken as the depth, widest delay and tap1
        write_setting(32'hFFFF_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 32'd1,
                      32'h0000_4000, 32'h0000_C000, 32'h0000_2000);
        send_word(SMP_MAX, SMP_MIN);
        send_word(32'h0055_AAAA, 32'h00AA_5555);
        send_word(SMP_MIN, SMP_MAX);
        send_word(32'd0, 32'd1);
        wait_for_results();

        // random phases, each with its own register set
        for (int phase = 0; phase < 12; phase++)
        begin
            random_setting();
            if (phase >= 10)
                quiet_mode = 1'b1;
            if (phase == 3)
            begin
                // long receiver hold while the sender keeps pushing
                random_words(8, 1'b0);
                hold_request = 1'b1;
                random_words(14, 1'b1);
                random_words(10, 1'b0);
            end
            else if (phase == 6)
            begin
                // sender pauses until the pipe is empty, then resumes
                random_words(16, 1'b0);
                wait_for_results();
                random_words(16, 1'b0);
            end
            else
                random_words(32, 1'b0);
            wait_for_results();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        drain_done <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial
    begin
        #500000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
